@@ src/ffa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types, widths and codes of the first-fit boundary tag allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int unsigned MemWords = 4096;
  localparam int unsigned AddrW    = 12;
  localparam int unsigned SizeW    = 13;
  localparam int unsigned TagW     = SizeW + 1;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [SizeW-1:0] size_t;
  typedef logic [TagW-1:0]  tag_t;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNoMem    = 2'd1;
  localparam logic [1:0] StSizeBad  = 2'd2;
  localparam logic [1:0] StAddrBad  = 2'd3;

  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;

  // datapath commands
  typedef enum logic [3:0] {
    CmdNone,
    CmdInitWr,
    CmdLoad,
    CmdRdHdr,
    CmdRdFtr,
    CmdRdLeft,
    CmdRdRight,
    CmdWrA,
    CmdWrB,
    CmdWrC,
    CmdWrD,
    CmdWrE,
    CmdWrF,
    CmdStep
  } cmd_e;

  typedef struct packed {
    cmd_e  cmd;
  } ctl_t;

  typedef struct packed {
    logic init_done;
    logic walk_end;
    logic walk_fail;
    logic fit;
    logic split;
    logic hdr_bad;
    logic ftr_bad;
    logic size_bad;
    logic left_free;
    logic right_free;
  } sts_t;

  function automatic tag_t make_tag(logic used, size_t sz);
    return {used, sz};
  endfunction

endpackage

@@ src/ffa_datapath.sv @@
// ----------------------------------------------------------------------------
// ffa_datapath
// Tag store, walk pointer and tag arithmetic of the allocator.
// ----------------------------------------------------------------------------
module ffa_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffa_pkg::ctl_t       ctl_i,
  input  logic                mode_i,
  input  ffa_pkg::addr_t      req_i,
  input  ffa_pkg::addr_t      baddr_i,
  output ffa_pkg::sts_t       sts_o,
  output ffa_pkg::addr_t      res_addr_o
);

  localparam ffa_pkg::size_t Total = ffa_pkg::size_t'(ffa_pkg::MemWords);

  ffa_pkg::tag_t  mem_q [ffa_pkg::MemWords];
  ffa_pkg::tag_t  rd_q;
  ffa_pkg::size_t init_q, init_d;
  ffa_pkg::size_t hdr_q, hdr_d;
  ffa_pkg::size_t need_q, need_d;
  ffa_pkg::size_t req_q, req_d;
  ffa_pkg::size_t fhdr_q, fhdr_d;
  ffa_pkg::size_t ftr_q, ftr_d;
  ffa_pkg::size_t nsz_q, nsz_d;
  ffa_pkg::size_t lhdr_q, lhdr_d;
  ffa_pkg::size_t rftr_q, rftr_d;
  ffa_pkg::tag_t  htag_q, htag_d;
  logic           lm_q, lm_d;
  logic           rm_q, rm_d;

  logic           we;
  ffa_pkg::size_t wa, ra;
  ffa_pkg::tag_t  wd;
  logic           re;
  ffa_pkg::size_t rsz;
  ffa_pkg::size_t rem;

  assign rsz = rd_q[ffa_pkg::SizeW-1:0];
  assign rem = rsz - need_q;

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    re = 1'b0;
    ra = '0;
    init_d = init_q;
    hdr_d = hdr_q;
    need_d = need_q;
    req_d = req_q;
    fhdr_d = fhdr_q;
    ftr_d = ftr_q;
    nsz_d = nsz_q;
    lhdr_d = lhdr_q;
    rftr_d = rftr_q;
    htag_d = htag_q;
    lm_d = lm_q;
    rm_d = rm_q;
    unique case (ctl_i.cmd)
      ffa_pkg::CmdInitWr: begin
        we = 1'b1;
        wa = init_q;
        if (init_q == 0 || init_q == 1 || init_q == Total - 2 || init_q == Total - 1) begin
          wd = ffa_pkg::make_tag(1'b1, ffa_pkg::size_t'(2));
        end else if (init_q == 2 || init_q == Total - 3) begin
          wd = ffa_pkg::make_tag(1'b0, Total - 4);
        end
        init_d = init_q + 1'b1;
      end
      ffa_pkg::CmdLoad: begin
        req_d = {1'b0, req_i};
        need_d = {1'b0, req_i} + ffa_pkg::size_t'(2);
        hdr_d = '0;
        fhdr_d = {1'b0, baddr_i} - 1'b1;
        re = 1'b1;
        ra = (mode_i == ffa_pkg::ModeFree) ? {1'b0, baddr_i} - 1'b1 : '0;
      end
      ffa_pkg::CmdRdHdr: begin
        re = 1'b1;
        ra = hdr_q;
      end
      ffa_pkg::CmdStep: begin
        hdr_d = hdr_q + rsz;
        re = 1'b1;
        ra = hdr_q + rsz;
      end
      ffa_pkg::CmdRdFtr: begin
        htag_d = rd_q;
        ftr_d = fhdr_q + rsz - 1'b1;
        nsz_d = rsz;
        lhdr_d = fhdr_q;
        rftr_d = fhdr_q + rsz - 1'b1;
        re = 1'b1;
        ra = fhdr_q + rsz - 1'b1;
      end
      ffa_pkg::CmdRdLeft: begin
        re = 1'b1;
        ra = fhdr_q - 1'b1;
      end
      ffa_pkg::CmdRdRight: begin
        lm_d = sts_o.left_free;
        if (sts_o.left_free) begin
          lhdr_d = fhdr_q - rsz;
          nsz_d = nsz_q + rsz;
        end
        re = 1'b1;
        ra = ftr_q + 1'b1;
      end
      ffa_pkg::CmdWrA: begin
        if (mode_i == ffa_pkg::ModeAlloc) begin
          we = 1'b1;
          wa = hdr_q;
          wd = ffa_pkg::make_tag(1'b1, sts_o.split ? need_q : rsz);
          fhdr_d = rsz;
        end else begin
          rm_d = sts_o.right_free;
          if (sts_o.right_free) begin
            rftr_d = ftr_q + rsz;
            nsz_d = nsz_q + rsz;
          end
          we = lm_q;
          wa = fhdr_q - 1'b1;
        end
      end
      ffa_pkg::CmdWrB: begin
        if (mode_i == ffa_pkg::ModeAlloc) begin
          we = 1'b1;
          wa = lm_q ? hdr_q + need_q - 1'b1 : hdr_q + fhdr_q - 1'b1;
          wd = ffa_pkg::make_tag(1'b1, lm_q ? need_q : fhdr_q);
        end else begin
          we = lm_q;
          wa = fhdr_q;
        end
      end
      ffa_pkg::CmdWrC: begin
        if (mode_i == ffa_pkg::ModeAlloc) begin
          we = 1'b1;
          wa = hdr_q + need_q;
          wd = ffa_pkg::make_tag(1'b0, fhdr_q - need_q);
        end else begin
          we = rm_q;
          wa = ftr_q + 1'b1;
        end
      end
      ffa_pkg::CmdWrD: begin
        if (mode_i == ffa_pkg::ModeAlloc) begin
          we = 1'b1;
          wa = hdr_q + fhdr_q - 1'b1;
          wd = ffa_pkg::make_tag(1'b0, fhdr_q - need_q);
        end else begin
          we = rm_q;
          wa = ftr_q;
        end
      end
      ffa_pkg::CmdWrE: begin
        we = 1'b1;
        wa = lhdr_q;
        wd = ffa_pkg::make_tag(1'b0, nsz_q);
      end
      ffa_pkg::CmdWrF: begin
        we = 1'b1;
        wa = rftr_q;
        wd = ffa_pkg::make_tag(1'b0, nsz_q);
      end
      default: begin
      end
    endcase
    // alloc: remember split decision in lm_q at WrA
    if (ctl_i.cmd == ffa_pkg::CmdWrA && mode_i == ffa_pkg::ModeAlloc) begin
      lm_d = sts_o.split;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa[ffa_pkg::AddrW-1:0]] <= wd;
    end
    if (re) begin
      rd_q <= mem_q[ra[ffa_pkg::AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0;
      lm_q <= 1'b0;
      rm_q <= 1'b0;
    end else begin
      init_q <= init_d;
      lm_q <= lm_d;
      rm_q <= rm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    need_q <= need_d;
    req_q <= req_d;
    fhdr_q <= fhdr_d;
    ftr_q <= ftr_d;
    nsz_q <= nsz_d;
    lhdr_q <= lhdr_d;
    rftr_q <= rftr_d;
    htag_q <= htag_d;
  end

  always_comb begin
    sts_o.init_done  = (init_q == Total);
    sts_o.walk_end   = (hdr_q >= Total);
    sts_o.walk_fail  = (rsz == 0) || (rsz > Total - hdr_q);
    sts_o.fit        = !rd_q[ffa_pkg::TagW-1] && (rsz >= need_q);
    sts_o.split      = (rem >= ffa_pkg::size_t'(2));
    sts_o.hdr_bad    = (fhdr_q < 2) || (fhdr_q > Total - 3) || !rd_q[ffa_pkg::TagW-1]
                       || (rsz < 2) || (rsz > Total - 2 - fhdr_q);
    sts_o.ftr_bad    = (rd_q != htag_q);
    sts_o.size_bad   = (nsz_q - 2'd2 != req_q) && (nsz_q - 2'd2 != req_q + 1'b1);
    sts_o.left_free  = !rd_q[ffa_pkg::TagW-1] && (rsz != 0) && (rsz <= fhdr_q);
    sts_o.right_free = !rd_q[ffa_pkg::TagW-1] && (rsz != 0)
                       && (rsz <= Total - ftr_q - 1'b1);
  end

  assign res_addr_o = ffa_pkg::addr_t'(hdr_q + 1'b1);

endmodule

@@ src/ffa_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer of the allocator: init sweep, first-fit walk and free merge.
// ----------------------------------------------------------------------------
module ffa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                mode_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic                addr_sel_o,
  output ffa_pkg::ctl_t       ctl_o,
  input  ffa_pkg::sts_t       sts_i
);

  localparam logic [4:0] SInit  = 5'd0;
  localparam logic [4:0] SIdle  = 5'd1;
  localparam logic [4:0] SWalk  = 5'd2;
  localparam logic [4:0] SAw1   = 5'd3;
  localparam logic [4:0] SAw2   = 5'd4;
  localparam logic [4:0] SAw3   = 5'd5;
  localparam logic [4:0] SFhdr  = 5'd6;
  localparam logic [4:0] SFftr  = 5'd7;
  localparam logic [4:0] SFl    = 5'd8;
  localparam logic [4:0] SFr    = 5'd9;
  localparam logic [4:0] SFw1   = 5'd10;
  localparam logic [4:0] SFw2   = 5'd11;
  localparam logic [4:0] SFw3   = 5'd12;
  localparam logic [4:0] SOut   = 5'd13;
  localparam logic [4:0] SAw0   = 5'd14;
  localparam logic [4:0] SFw4   = 5'd15;
  localparam logic [4:0] SFw5   = 5'd16;

  logic [4:0] st_q, st_d;
  logic [1:0] stat_q, stat_d;
  logic       asel_q, asel_d;

  assign in_ready_o  = (st_q == SIdle);
  assign out_valid_o = (st_q == SOut);
  assign status_o    = stat_q;
  assign addr_sel_o  = asel_q;

  always_comb begin
    st_d = st_q;
    stat_d = stat_q;
    asel_d = asel_q;
    ctl_o.cmd = ffa_pkg::CmdNone;
    unique case (st_q)
      SInit: begin
        if (sts_i.init_done) begin
          st_d = SIdle;
        end else begin
          ctl_o.cmd = ffa_pkg::CmdInitWr;
        end
      end
      SIdle: begin
        if (in_valid_i) begin
          ctl_o.cmd = ffa_pkg::CmdLoad;
          asel_d = 1'b0;
          st_d = (mode_i == ffa_pkg::ModeFree) ? SFhdr : SWalk;
        end
      end
      SWalk: begin
        if (sts_i.walk_end || sts_i.walk_fail) begin
          stat_d = ffa_pkg::StNoMem;
          st_d = SOut;
        end else if (sts_i.fit) begin
          stat_d = ffa_pkg::StOk;
          asel_d = 1'b1;
          st_d = SAw0;
        end else begin
          ctl_o.cmd = ffa_pkg::CmdStep;
        end
      end
      SAw0: begin
        ctl_o.cmd = ffa_pkg::CmdWrA;
        st_d = SAw1;
      end
      SAw1: begin
        ctl_o.cmd = ffa_pkg::CmdWrB;
        st_d = sts_i.split ? SAw2 : SOut;
      end
      SAw2: begin
        ctl_o.cmd = ffa_pkg::CmdWrC;
        st_d = SAw3;
      end
      SAw3: begin
        ctl_o.cmd = ffa_pkg::CmdWrD;
        st_d = SOut;
      end
      SFhdr: begin
        if (sts_i.hdr_bad) begin
          stat_d = ffa_pkg::StAddrBad;
          st_d = SOut;
        end else begin
          ctl_o.cmd = ffa_pkg::CmdRdFtr;
          st_d = SFftr;
        end
      end
      SFftr: begin
        if (sts_i.ftr_bad) begin
          stat_d = ffa_pkg::StAddrBad;
          st_d = SOut;
        end else if (sts_i.size_bad) begin
          stat_d = ffa_pkg::StSizeBad;
          st_d = SOut;
        end else begin
          stat_d = ffa_pkg::StOk;
          ctl_o.cmd = ffa_pkg::CmdRdLeft;
          st_d = SFl;
        end
      end
      SFl: begin
        ctl_o.cmd = ffa_pkg::CmdRdRight;
        st_d = SFr;
      end
      SFr: begin
        ctl_o.cmd = ffa_pkg::CmdWrA;
        st_d = SFw1;
      end
      SFw1: begin
        ctl_o.cmd = ffa_pkg::CmdWrB;
        st_d = SFw2;
      end
      SFw2: begin
        ctl_o.cmd = ffa_pkg::CmdWrC;
        st_d = SFw3;
      end
      SFw3: begin
        ctl_o.cmd = ffa_pkg::CmdWrD;
        st_d = SFw4;
      end
      SFw4: begin
        ctl_o.cmd = ffa_pkg::CmdWrE;
        st_d = SFw5;
      end
      SFw5: begin
        ctl_o.cmd = ffa_pkg::CmdWrF;
        st_d = SOut;
      end
      SOut: begin
        if (out_ready_i) begin
          st_d = SIdle;
        end
      end
      default: begin
        st_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SInit;
      stat_q <= ffa_pkg::StOk;
      asel_q <= 1'b0;
    end else begin
      st_q <= st_d;
      stat_q <= stat_d;
      asel_q <= asel_d;
    end
  end

endmodule

@@ src/first_fit_boundary_tag_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_boundary_tag_allocator
// First-fit heap allocator over a 4096-word boundary tag store.
// ----------------------------------------------------------------------------
// Input channel s_axis: one transaction is an allocate or a free request.
// Output channel m_axis: one transaction per request with status and address.
// An allocate walks block headers, one store read per cycle, then writes
// the header and footer tags, and the tags of the remainder as well when
// the block is split. Out of memory is reported when the walk passes the
// end of the store. The walk length sets the time. A free reads the
// header, the footer and both neighbour tags, then takes six tag write
// steps, four of which write only when a neighbour merges; a bad address
// ends at the header or footer check, a size mismatch at the footer check.
// The result then sits in the output register; after its transaction the
// block returns to idle before the next request is taken, so one request
// is in flight at a time. After reset the tag store is swept, one word a
// cycle; the first request is accepted once the sweep ends. While the
// receiver stalls the result is held and no new request is accepted.
// ----------------------------------------------------------------------------
module first_fit_boundary_tag_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // req_words[11:0], block_address[23:12]
  input  logic        s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // status[1:0], address[13:2], zero[15:14]
);

  ffa_pkg::ctl_t  ctl;
  ffa_pkg::sts_t  sts;
  ffa_pkg::addr_t res_addr;
  logic [1:0]     status;
  logic           asel;
  logic           mode_q;
  ffa_pkg::addr_t req_q, badr_q;
  logic           mode;
  ffa_pkg::addr_t req, badr;

  assign mode = s_axis_tready ? s_axis_tuser : mode_q;
  assign req  = s_axis_tready ? s_axis_tdata[11:0] : req_q;
  assign badr = s_axis_tready ? s_axis_tdata[23:12] : badr_q;

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      mode_q <= s_axis_tuser;
      req_q <= s_axis_tdata[11:0];
      badr_q <= s_axis_tdata[23:12];
    end
  end

  ffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .mode_i      (mode),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .addr_sel_o  (asel),
    .ctl_o       (ctl),
    .sts_i       (sts)
  );

  ffa_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .mode_i     (mode),
    .req_i      (req),
    .baddr_i    (badr),
    .sts_o      (sts),
    .res_addr_o (res_addr)
  );

  assign m_axis_tdata = {2'b00, (asel ? res_addr : ffa_pkg::addr_t'(0)), status};

endmodule
